// File: src/i2cs_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the I2C master transfer sequencer.
// No dependencies; imported by the top level and by i2cs_ctrl.
package i2cs_pkg;

    // Event kinds carried on the input tuser
    localparam logic [2:0] KIND_BEGIN     = 3'd0;
    localparam logic [2:0] KIND_LOAD      = 3'd1;
    localparam logic [2:0] KIND_START_SENT = 3'd2;
    localparam logic [2:0] KIND_ADDR_ACK  = 3'd3;
    localparam logic [2:0] KIND_TX_EMPTY  = 3'd4;
    localparam logic [2:0] KIND_RX_BYTE   = 3'd5;
    localparam logic [2:0] KIND_ERROR     = 3'd6;

    // Error kinds
    localparam logic [1:0] ERR_BUS  = 2'd0;
    localparam logic [1:0] ERR_ARLO = 2'd1;
    localparam logic [1:0] ERR_NACK = 2'd2;

    // Transfer status codes
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_BUSY = 3'd1;
    localparam logic [2:0] ST_OK   = 3'd2;
    localparam logic [2:0] ST_BERR = 3'd3;
    localparam logic [2:0] ST_ARLO = 3'd4;
    localparam logic [2:0] ST_NACK = 3'd5;

    // Enable/disable actions for ACK and buffer interrupts
    localparam logic [1:0] ACT_LEAVE   = 2'd0;
    localparam logic [1:0] ACT_ENABLE  = 2'd1;
    localparam logic [1:0] ACT_DISABLE = 2'd2;

    // Read phase never exceeds this many bytes
    localparam logic [6:0] READ_MAX = 7'd64;

    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 40;

    typedef struct packed {
        logic [2:0] kind;
        logic [6:0] slave_address;
        logic [6:0] write_count;
        logic [6:0] read_count;
        logic [5:0] byte_index;
        logic [7:0] data_byte;
        logic       transfer_finished;
        logic [1:0] error_kind;
    } t_item;

    typedef struct packed {
        logic       drive_valid;
        logic [7:0] drive_byte;
        logic       gen_start;
        logic       gen_stop;
        logic [1:0] ack_action;
        logic [1:0] buffer_irq_action;
        logic       event_irq_off;
        logic       read_valid;
        logic [7:0] read_byte;
        logic [5:0] read_index;
        logic [2:0] status;
    } t_result;

endpackage

// File: src/i2c_master_transfer_sequencer_unit.sv
`timescale 1ns / 1ps
// Top level of the I2C master transfer sequencer: stream ports, input and
// result registers. Depends on i2cs_pkg, i2cs_ctrl and i2cs_wbuf.
//
//  channel   | dir | tdata (low bit up)                               | tuser
//  ----------+-----+--------------------------------------------------+-------
//  s (event) | in  | slave_address, write_count, read_count,          | kind
//            |     | byte_index, data_byte, transfer_finished,        |
//            |     | error_kind                                       |
//  m (action)| out | drive_valid, drive_byte, gen_start, gen_stop,    | -
//            |     | ack_action, buffer_irq_action, event_irq_off,    |
//            |     | read_valid, read_byte, read_index, status        |
//
// One event per clock sustained while the output is not stalled.
// The input register feeds the decision logic, which loads the result register;
// the write buffer reads one item ahead so its registered read is ready in time.
// A stalled result holds both registers; s_tready drops only when both are full.
// Reset is synchronous, active low, and clears all transfer state at once.
module i2c_master_transfer_sequencer_unit #(
    parameter int BUF_DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // [6:0] slave_address, [13:7] write_count, [20:14] read_count,
    // [26:21] byte_index, [34:27] data_byte, [35] transfer_finished,
    // [37:36] error_kind, [39:38] zero
    input  logic [i2cs_pkg::IN_DATA_W-1:0]  i_s_tdata,
    // [2:0] kind
    input  logic [2:0]  i_s_tuser,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // [0] drive_valid, [8:1] drive_byte, [9] gen_start, [10] gen_stop,
    // [12:11] ack_action, [14:13] buffer_irq_action, [15] event_irq_off,
    // [16] read_valid, [24:17] read_byte, [30:25] read_index, [33:31] status,
    // [39:34] zero
    output logic [i2cs_pkg::OUT_DATA_W-1:0] o_m_tdata
);
    import i2cs_pkg::*;

    localparam int AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;

    logic    r_in_vld;
    t_item   r_item;
    logic    r_out_vld;
    t_result r_result;
    logic    advance;
    logic    step;
    t_result result;
    logic    wr_en;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;
    logic [7:0]    rd_data;

    assign advance    = !r_out_vld || i_m_tready;
    assign step       = r_in_vld && advance;
    assign o_s_tready = !r_in_vld || advance;

    // Capture an accepted event
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_s_tready) begin
            r_in_vld <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_item.kind              <= i_s_tuser;
            r_item.slave_address     <= i_s_tdata[6:0];
            r_item.write_count       <= i_s_tdata[13:7];
            r_item.read_count        <= i_s_tdata[20:14];
            r_item.byte_index        <= i_s_tdata[26:21];
            r_item.data_byte         <= i_s_tdata[34:27];
            r_item.transfer_finished <= i_s_tdata[35];
            r_item.error_kind        <= i_s_tdata[37:36];
        end
    end

    i2cs_ctrl #(
        .BUF_DEPTH (BUF_DEPTH),
        .AW        (AW)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (step),
        .i_item    (r_item),
        .i_rd_data (rd_data),
        .o_wr_en   (wr_en),
        .o_wr_addr (wr_addr),
        .o_rd_addr (rd_addr),
        .o_result  (result)
    );

    i2cs_wbuf #(
        .DEPTH (BUF_DEPTH),
        .AW    (AW)
    ) u_wbuf (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (r_item.data_byte),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Load the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_result <= result;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {6'd0,
                         r_result.status,
                         r_result.read_index,
                         r_result.read_byte,
                         r_result.read_valid,
                         r_result.event_irq_off,
                         r_result.buffer_irq_action,
                         r_result.ack_action,
                         r_result.gen_stop,
                         r_result.gen_start,
                         r_result.drive_byte,
                         r_result.drive_valid};

`ifndef SYNTHESIS
    // A delivered read byte only comes from a live or just-finished transfer
    a_read_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_result.read_valid) |->
            (r_result.status == ST_BUSY || r_result.status == ST_OK))
        else $error("read byte delivered outside a transfer");
    // A stop always ends the transfer
    a_stop_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_result.gen_stop) |-> (r_result.status != ST_BUSY))
        else $error("stop requested while still busy");
    // Never drive and deliver in the same result
    a_drive_xor_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> !(r_result.drive_valid && r_result.read_valid))
        else $error("drive and read in one result");
    // Every start comes with buffer events turned on
    a_start_irq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_result.gen_start) |-> (r_result.buffer_irq_action == ACT_ENABLE))
        else $error("start without buffer events enabled");
`endif

endmodule

// File: src/i2cs_wbuf.sv
`timescale 1ns / 1ps
// Write byte buffer: one write port, one registered read port with write bypass.
// Depends on nothing; instantiated by the top level.
module i2cs_wbuf #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [7:0]    i_wr_data,
    input  logic [AW-1:0] i_rd_addr,
    output logic [7:0]    o_rd_data
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rd_data;

    // Store loaded bytes
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read ahead; take the new byte when it lands on the same slot
    always_ff @(posedge i_clk) begin
        if (i_wr_en && (i_wr_addr == i_rd_addr)) begin
            r_rd_data <= i_wr_data;
        end else begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: src/i2cs_ctrl.sv
`timescale 1ns / 1ps
// Transfer state and per-event decision logic of the sequencer.
// Depends on i2cs_pkg; drives the write buffer read address one item ahead.
module i2cs_ctrl #(
    parameter int BUF_DEPTH = 64,
    parameter int AW        = 6
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  i2cs_pkg::t_item   i_item,
    input  logic [7:0]        i_rd_data,
    output logic              o_wr_en,
    output logic [AW-1:0]     o_wr_addr,
    output logic [AW-1:0]     o_rd_addr,
    output i2cs_pkg::t_result o_result
);
    import i2cs_pkg::*;

    logic       r_read_phase, n_read_phase;
    logic [6:0] r_target, n_target;
    logic [6:0] r_wr_wanted, n_wr_wanted;
    logic [6:0] r_rd_wanted, n_rd_wanted;
    logic [6:0] r_wr_done, n_wr_done;
    logic [6:0] r_rd_done, n_rd_done;
    logic [2:0] r_status, n_status;

    logic       busy;
    logic [6:0] wr_done_inc;
    logic [6:0] rd_done_inc;
    logic [7:0] rd_done_inc2;
    logic       more_writes;
    logic [6:0] begin_ww;
    logic [6:0] begin_rw;
    t_result    res;

    assign busy         = (r_status == ST_BUSY);
    assign wr_done_inc  = r_wr_done + 7'd1;
    assign rd_done_inc  = r_rd_done + 7'd1;
    assign rd_done_inc2 = {1'b0, rd_done_inc} + 8'd1;
    assign more_writes  = (r_wr_done < r_wr_wanted);
    assign begin_ww     = (32'(i_item.write_count) > BUF_DEPTH) ? 7'(BUF_DEPTH)
                                                                 : i_item.write_count;
    assign begin_rw     = (i_item.read_count > READ_MAX) ? READ_MAX : i_item.read_count;

    // Decide bus actions and next state for the item in the input register
    always_comb begin
        res          = '0;
        n_read_phase = r_read_phase;
        n_target     = r_target;
        n_wr_wanted  = r_wr_wanted;
        n_rd_wanted  = r_rd_wanted;
        n_wr_done    = r_wr_done;
        n_rd_done    = r_rd_done;
        n_status     = r_status;
        o_wr_en      = 1'b0;

        if (i_step) begin
            unique case (i_item.kind) inside
                KIND_BEGIN: begin
                    n_status     = ST_BUSY;
                    n_target     = i_item.slave_address;
                    n_wr_wanted  = begin_ww;
                    n_rd_wanted  = begin_rw;
                    n_wr_done    = '0;
                    n_rd_done    = '0;
                    n_read_phase = (begin_ww == '0) && (begin_rw != '0);
                    res.gen_start         = 1'b1;
                    res.buffer_irq_action = ACT_ENABLE;
                    if ((begin_ww == '0) && (begin_rw != '0)) begin
                        res.ack_action = ACT_ENABLE;
                    end
                end
                KIND_LOAD: begin
                    o_wr_en = (32'(i_item.byte_index) < BUF_DEPTH);
                end
                KIND_START_SENT: begin
                    if (busy) begin
                        res.drive_valid = 1'b1;
                        res.drive_byte  = {r_target, r_read_phase};
                    end
                end
                KIND_ADDR_ACK, KIND_TX_EMPTY: begin
                    if (busy && !r_read_phase && more_writes) begin
                        // Drive the next write byte; quiet buffer events after the last
                        res.drive_valid = 1'b1;
                        res.drive_byte  = i_rd_data;
                        n_wr_done       = wr_done_inc;
                        if (wr_done_inc == r_wr_wanted) begin
                            res.buffer_irq_action = ACT_DISABLE;
                        end
                    end else if (i_item.kind == KIND_ADDR_ACK) begin
                        if (busy && r_read_phase && (r_rd_wanted == 7'd1)) begin
                            res.ack_action = ACT_DISABLE;
                        end
                    end else if (busy && !r_read_phase && i_item.transfer_finished) begin
                        if (r_rd_wanted != '0) begin
                            // Repeated start into the read phase
                            n_read_phase          = 1'b1;
                            n_rd_done             = '0;
                            res.buffer_irq_action = ACT_ENABLE;
                            res.gen_start         = 1'b1;
                            res.ack_action        = ACT_ENABLE;
                        end else begin
                            res.gen_stop      = 1'b1;
                            res.event_irq_off = 1'b1;
                            n_status          = ST_OK;
                        end
                    end
                end
                KIND_RX_BYTE: begin
                    if (busy && r_read_phase && (r_rd_done < r_rd_wanted)) begin
                        res.read_valid = 1'b1;
                        res.read_byte  = i_item.data_byte;
                        res.read_index = r_rd_done[5:0];
                        n_rd_done      = rd_done_inc;
                        if (rd_done_inc2 == {1'b0, r_rd_wanted}) begin
                            res.ack_action = ACT_DISABLE;
                        end else if (rd_done_inc == r_rd_wanted) begin
                            res.gen_stop = 1'b1;
                            n_status     = ST_OK;
                        end
                    end
                end
                KIND_ERROR: begin
                    unique case (i_item.error_kind)
                        ERR_ARLO: n_status = ST_ARLO;
                        ERR_NACK: n_status = ST_NACK;
                        default:  n_status = ST_BERR;
                    endcase
                    res.gen_stop = 1'b1;
                end
                default: begin
                end
            endcase
        end
        res.status = n_status;
    end

    assign o_result  = res;
    assign o_wr_addr = AW'(i_item.byte_index);
    assign o_rd_addr = AW'(n_wr_done);

    // Hold transfer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_read_phase <= 1'b0;
            r_target     <= '0;
            r_wr_wanted  <= '0;
            r_rd_wanted  <= '0;
            r_wr_done    <= '0;
            r_rd_done    <= '0;
            r_status     <= ST_IDLE;
        end else begin
            r_read_phase <= n_read_phase;
            r_target     <= n_target;
            r_wr_wanted  <= n_wr_wanted;
            r_rd_wanted  <= n_rd_wanted;
            r_wr_done    <= n_wr_done;
            r_rd_done    <= n_rd_done;
            r_status     <= n_status;
        end
    end

`ifndef SYNTHESIS
    // Counters never run past what the transfer asked for
    a_wr_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wr_done <= r_wr_wanted)
        else $error("write count passed requested writes");
    a_rd_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_done <= r_rd_wanted)
        else $error("read count passed requested reads");
    // Requested reads stay saturated
    a_rd_wanted_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_wanted <= READ_MAX)
        else $error("requested reads above the read limit");
`endif

endmodule
